// ===== hw/rtl/octant_voxel_density_histogram_macros.svh =====
// assertion helpers for the voxel histogram
`ifndef OCTANT_VOXEL_DENSITY_HISTOGRAM_MACROS_SVH
`define OCTANT_VOXEL_DENSITY_HISTOGRAM_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define OVDH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define OVDH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ovdh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ovdh_pkg;

    localparam int DEF_BINS_X  = 16;
    localparam int DEF_BINS_Y  = 16;
    localparam int DEF_BINS_Z  = 16;
    localparam int OCTANTS     = 8;

    localparam int POS_W       = 24;
    localparam int BIN_W       = 4;
    localparam int OCT_W       = 3;
    localparam int SIZE_W      = 16;
    localparam int THR_W       = 31;
    localparam int CNT_W       = 32;
    localparam int CTR_W       = 21;
    localparam int CFG_W       = 31;

    localparam logic [SIZE_W-1:0] BIN_SIZE_RST = 16'd256;
    localparam logic [CTR_W-1:0]  CENTRE_MAX   = 21'd1048575;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic CFG_BIN_SIZE  = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    typedef enum logic [1:0] {
        DC_LOW  = 2'd0,
        DC_MID  = 2'd1,
        DC_HIGH = 2'd2
    } t_dclass;

    typedef struct packed {
        logic             is_read;
        logic [POS_W-1:0] mag_x;
        logic [POS_W-1:0] mag_y;
        logic [POS_W-1:0] mag_z;
        logic [OCT_W-1:0] oct;
        logic [BIN_W-1:0] bin_x;
        logic [BIN_W-1:0] bin_y;
        logic [BIN_W-1:0] bin_z;
        logic             rd_in_range;
    } t_item;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_IDX,
        S_ACHK,
        S_AWR,
        S_RWAIT
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/ovdh_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ovdh_front #(
    parameter int BINS_X = 16,
    parameter int BINS_Y = 16,
    parameter int BINS_Z = 16
) (
    input  wire logic                            i_action,
    input  wire logic signed [ovdh_pkg::POS_W-1:0] i_pos_x,
    input  wire logic signed [ovdh_pkg::POS_W-1:0] i_pos_y,
    input  wire logic signed [ovdh_pkg::POS_W-1:0] i_pos_z,
    input  wire logic [ovdh_pkg::BIN_W-1:0]      i_bin_x,
    input  wire logic [ovdh_pkg::BIN_W-1:0]      i_bin_y,
    input  wire logic [ovdh_pkg::BIN_W-1:0]      i_bin_z,
    input  wire logic [ovdh_pkg::OCT_W-1:0]      i_octant,
    output ovdh_pkg::t_item                      o_item
);
    import ovdh_pkg::*;

    logic [8:0] bx_ext, by_ext, bz_ext;

    always_comb begin
        bx_ext = {5'd0, i_bin_x};
        by_ext = {5'd0, i_bin_y};
        bz_ext = {5'd0, i_bin_z};
        o_item.is_read = (i_action == ACT_READ);
        // magnitude of the most negative value still fits unsigned
        o_item.mag_x = i_pos_x[POS_W-1] ? POS_W'(-i_pos_x) : POS_W'(i_pos_x);
        o_item.mag_y = i_pos_y[POS_W-1] ? POS_W'(-i_pos_y) : POS_W'(i_pos_y);
        o_item.mag_z = i_pos_z[POS_W-1] ? POS_W'(-i_pos_z) : POS_W'(i_pos_z);
        if (i_action == ACT_READ) begin
            o_item.oct = i_octant;
        end else begin
            o_item.oct = {~i_pos_z[POS_W-1], ~i_pos_y[POS_W-1], ~i_pos_x[POS_W-1]};
        end
        o_item.bin_x = i_bin_x;
        o_item.bin_y = i_bin_y;
        o_item.bin_z = i_bin_z;
        o_item.rd_in_range = (bx_ext < 9'(BINS_X)) && (by_ext < 9'(BINS_Y))
                          && (bz_ext < 9'(BINS_Z));
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ovdh_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ovdh_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  ovdh_pkg::t_item      i_item,
    input  wire logic            i_pop,
    output ovdh_pkg::t_item      o_item,
    output logic                 o_empty,
    output logic                 o_full
);
    import ovdh_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_item  = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

endmodule
`default_nettype wire

// ===== hw/rtl/ovdh_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ovdh_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ovdh_pkg::POS_W-1:0]  i_dividend,
    input  wire logic [ovdh_pkg::SIZE_W-1:0] i_divisor,
    output logic                             o_done,
    output logic [ovdh_pkg::POS_W-1:0]       o_quot
);
    import ovdh_pkg::*;

    localparam int STEP_W = $clog2(POS_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [POS_W-1:0]  r_quot;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_div;
    logic [SIZE_W:0]   shifted;
    logic [SIZE_W:0]   diff;
    logic              q_bit;

    // restoring division, one quotient bit a cycle
    always_comb begin
        shifted = {r_rem, r_quot[POS_W-1]};
        diff    = shifted - {1'b0, r_div};
        q_bit   = (shifted >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[POS_W-2:0], q_bit};
            r_rem  <= q_bit ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(POS_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// ===== hw/rtl/ovdh_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ovdh_back #(
    parameter int BINS_X = 16,
    parameter int BINS_Y = 16,
    parameter int BINS_Z = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [ovdh_pkg::SIZE_W-1:0] i_bin_size,
    input  wire logic [ovdh_pkg::THR_W-1:0]  i_threshold,
    input  ovdh_pkg::t_item                  i_item,
    input  wire logic                        i_empty,
    output logic                             o_pop,
    output logic                             o_clearing,
    output logic                             o_strobe,
    output logic                             o_accepted,
    output logic [ovdh_pkg::CNT_W-1:0]       o_bin_count,
    output logic                             o_occupied,
    output logic [1:0]                       o_density_class,
    output logic signed [ovdh_pkg::CTR_W-1:0] o_centre_x,
    output logic signed [ovdh_pkg::CTR_W-1:0] o_centre_y,
    output logic signed [ovdh_pkg::CTR_W-1:0] o_centre_z
);
    import ovdh_pkg::*;

    localparam int TABLE  = BINS_X * BINS_Y * BINS_Z;
    localparam int DEPTH  = OCTANTS * TABLE;
    localparam int AW     = $clog2(DEPTH);
    localparam int PLANE  = BINS_X * BINS_Y;
    localparam int LW     = POS_W + $clog2(PLANE + 1) + 2;

    logic [CNT_W-1:0] mem [DEPTH];

    t_state r_state, n_state;
    t_item  r_item;
    logic [AW-1:0]    r_clr_addr;
    logic [AW-1:0]    r_addr;
    logic             r_ok;
    logic [CNT_W-1:0] r_rdata;

    logic             mem_we, mem_re, div_start;
    logic [AW-1:0]    wr_addr, rd_addr, rd_head_addr;
    logic [CNT_W-1:0] wdata;
    logic [POS_W-1:0] q_x, q_y, q_z;
    logic             done_x, done_y, done_z;
    logic [LW-1:0]    lin;
    logic [CNT_W-1:0] cnt, excess;
    logic             occ;
    t_dclass          dcls;
    logic [CTR_W-1:0] ctr_x, ctr_y, ctr_z;

    logic             r_strobe, r_accepted, r_occupied;
    logic [CNT_W-1:0] r_count;
    logic [1:0]       r_dclass;
    logic [CTR_W-1:0] r_cx, r_cy, r_cz;

    ovdh_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(i_item.mag_x), .i_divisor(i_bin_size), .o_done(done_x), .o_quot(q_x)
    );
    ovdh_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(i_item.mag_y), .i_divisor(i_bin_size), .o_done(done_y), .o_quot(q_y)
    );
    ovdh_div u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(i_item.mag_z), .i_divisor(i_bin_size), .o_done(done_z), .o_quot(q_z)
    );

    function automatic logic [CTR_W-1:0] centre(input logic [BIN_W-1:0] idx,
                                                input logic [SIZE_W-1:0] size,
                                                input logic pos);
        logic [SIZE_W+BIN_W+1:0] prod;
        logic [CTR_W-1:0]        mag;
        begin
            prod = ({1'b0, idx, 1'b1} * (SIZE_W + BIN_W + 2)'(size)) >> 1;
            mag  = (prod > (SIZE_W + BIN_W + 2)'(CENTRE_MAX)) ? CENTRE_MAX
                                                            : CTR_W'(prod);
            centre = pos ? mag : CTR_W'(-mag);
        end
    endfunction

    // head-of-queue read address for a bin lookup, and linear voxel index for an add
    always_comb begin
        rd_head_addr = AW'(AW'(i_item.oct) * AW'(TABLE) + AW'(i_item.bin_x)
                     + AW'(BINS_X) * AW'(i_item.bin_y) + AW'(PLANE) * AW'(i_item.bin_z));
        lin = LW'(q_x) + LW'(BINS_X) * LW'(q_y) + LW'(PLANE) * LW'(q_z);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_addr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (!i_empty) n_state = i_item.is_read ? S_RWAIT : S_DIV;
            S_DIV:   if (done_x && done_y && done_z) n_state = S_IDX;
            S_IDX:   n_state = S_ACHK;
            S_ACHK:  n_state = r_ok ? S_AWR : S_IDLE;
            S_AWR:   n_state = S_IDLE;
            S_RWAIT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        div_start = 1'b0;
        o_pop     = 1'b0;
        wr_addr   = r_addr;
        rd_addr   = r_addr;
        wdata     = (r_rdata == '1) ? r_rdata : r_rdata + 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                mem_we  = 1'b1;
                wr_addr = r_clr_addr;
                wdata   = '0;
            end
            S_IDLE: begin
                o_pop = !i_empty;
                if (!i_empty) begin
                    if (i_item.is_read) begin
                        mem_re  = i_item.rd_in_range;
                        rd_addr = rd_head_addr;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            S_ACHK:  mem_re = r_ok;
            S_AWR:   mem_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // read result
    always_comb begin
        cnt    = r_item.rd_in_range ? r_rdata : '0;
        occ    = cnt > {1'b0, i_threshold};
        excess = cnt - {1'b0, i_threshold};
        if (!occ || excess < 32'd10) begin
            dcls = DC_LOW;
        end else if (excess < 32'd100) begin
            dcls = DC_MID;
        end else begin
            dcls = DC_HIGH;
        end
        ctr_x = centre(r_item.bin_x, i_bin_size, r_item.oct[0]);
        ctr_y = centre(r_item.bin_y, i_bin_size, r_item.oct[1]);
        ctr_z = centre(r_item.bin_z, i_bin_size, r_item.oct[2]);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && !i_empty) begin
            r_item <= i_item;
        end
        if (r_state == S_IDX) begin
            r_ok   <= (lin < LW'(TABLE)) && (i_bin_size != '0);
            r_addr <= AW'(AW'(r_item.oct) * AW'(TABLE) + lin[AW-1:0]);
        end
        r_accepted <= 1'b0;
        r_count    <= '0;
        r_occupied <= 1'b0;
        r_dclass   <= DC_LOW;
        r_cx       <= '0;
        r_cy       <= '0;
        r_cz       <= '0;
        if (r_state == S_AWR) begin
            r_accepted <= 1'b1;
        end else if (r_state == S_RWAIT) begin
            r_accepted <= 1'b1;
            r_count    <= cnt;
            r_occupied <= occ;
            r_dclass   <= dcls;
            r_cx       <= ctr_x;
            r_cy       <= ctr_y;
            r_cz       <= ctr_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= r_clr_addr + 1'b1;
            r_strobe   <= (r_state == S_AWR) || (r_state == S_RWAIT)
                       || (r_state == S_ACHK && !r_ok);
        end
    end

    assign o_clearing      = (r_state == S_CLEAR);
    assign o_strobe        = r_strobe;
    assign o_accepted      = r_accepted;
    assign o_bin_count     = r_count;
    assign o_occupied      = r_occupied;
    assign o_density_class = r_dclass;
    assign o_centre_x      = r_cx;
    assign o_centre_y      = r_cy;
    assign o_centre_z      = r_cz;

endmodule
`default_nettype wire

// ===== hw/rtl/octant_voxel_density_histogram.sv =====
// Octant voxel density histogram: eight 3-D count tables, one per octant.
// Command channel: an item is taken at a rising edge with start high and busy low.
// action 0 adds the point pos_x/y/z (signed Q16.8) to its octant's voxel; action 1
// reads voxel bin_x/y/z of octant and returns count, occupancy, density class
// and signed bin centre. Every item gives exactly one result, shown for one cycle
// with o_strobe high; the receiver cannot stall, so results are never held.
// Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 bin_size,
// 1 count_threshold) at once; write only while the block is idle.
// Order of work: a read looks up its count memory word as it leaves the queue, and
// its result is then registered; an add runs the 24-step restoring dividers (one
// quotient bit a cycle), an index step and a read-modify-write of the count memory.
// Flow: one item in the back end at a time, so the block does not start a new item
// before the last is through; a two-entry queue lets the front take items meanwhile,
// and busy rises when it is full.
// Reset: synchronous, active low. After reset a clearing pass zeroes all
// 8*BINS_X*BINS_Y*BINS_Z entries of the count memory (32768 by default), one entry
// a cycle, with busy held high throughout.
`timescale 1ns / 1ps
`default_nettype none
`include "octant_voxel_density_histogram_macros.svh"
module octant_voxel_density_histogram #(
    parameter int BINS_X = ovdh_pkg::DEF_BINS_X,
    parameter int BINS_Y = ovdh_pkg::DEF_BINS_Y,
    parameter int BINS_Z = ovdh_pkg::DEF_BINS_Z
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_action,
    input  wire logic signed [ovdh_pkg::POS_W-1:0] i_pos_x,
    input  wire logic signed [ovdh_pkg::POS_W-1:0] i_pos_y,
    input  wire logic signed [ovdh_pkg::POS_W-1:0] i_pos_z,
    input  wire logic [ovdh_pkg::BIN_W-1:0]        i_bin_x,
    input  wire logic [ovdh_pkg::BIN_W-1:0]        i_bin_y,
    input  wire logic [ovdh_pkg::BIN_W-1:0]        i_bin_z,
    input  wire logic [ovdh_pkg::OCT_W-1:0]        i_octant,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_idx,
    input  wire logic [ovdh_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                                   o_strobe,
    output logic                                   o_accepted,
    output logic [ovdh_pkg::CNT_W-1:0]             o_bin_count,
    output logic                                   o_occupied,
    output logic [1:0]                             o_density_class,
    output logic signed [ovdh_pkg::CTR_W-1:0]      o_centre_x,
    output logic signed [ovdh_pkg::CTR_W-1:0]      o_centre_y,
    output logic signed [ovdh_pkg::CTR_W-1:0]      o_centre_z
);
    import ovdh_pkg::*;

    logic [SIZE_W-1:0] r_bin_size;
    logic [THR_W-1:0]  r_threshold;
    t_item             fe_item, q_item;
    logic              q_empty, q_full, q_push, q_pop, clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_size  <= BIN_SIZE_RST;
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BIN_SIZE:  r_bin_size  <= i_cfg_data[SIZE_W-1:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy   = clearing || q_full;
    assign q_push = start && !busy;

    ovdh_front #(.BINS_X(BINS_X), .BINS_Y(BINS_Y), .BINS_Z(BINS_Z)) u_front (
        .i_action(i_action), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_bin_x(i_bin_x), .i_bin_y(i_bin_y), .i_bin_z(i_bin_z), .i_octant(i_octant),
        .o_item(fe_item)
    );

    ovdh_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(q_push), .i_item(fe_item),
        .i_pop(q_pop), .o_item(q_item), .o_empty(q_empty), .o_full(q_full)
    );

    ovdh_back #(.BINS_X(BINS_X), .BINS_Y(BINS_Y), .BINS_Z(BINS_Z)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_bin_size(r_bin_size),
        .i_threshold(r_threshold), .i_item(q_item), .i_empty(q_empty),
        .o_pop(q_pop), .o_clearing(clearing), .o_strobe(o_strobe),
        .o_accepted(o_accepted), .o_bin_count(o_bin_count), .o_occupied(o_occupied),
        .o_density_class(o_density_class), .o_centre_x(o_centre_x),
        .o_centre_y(o_centre_y), .o_centre_z(o_centre_z)
    );

    `OVDH_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_strobe, !o_strobe, "back-to-back results")
    `OVDH_ASSERT_IMP(a_occ_nonzero, i_clk, i_rst_n, o_strobe && o_occupied, o_bin_count != '0, "occupied with zero count")
    `OVDH_ASSERT_IMP(a_no_pop_clear, i_clk, i_rst_n, clearing, !q_pop && !o_strobe, "activity during clearing pass")

endmodule
`default_nettype wire
